[src/srv_pkg.sv]
package srv_pkg;

	localparam int COMB_NUM = 4;
	localparam int COMB_DELAY [COMB_NUM] = '{1309, 1636, 1812, 1927};
	localparam int ALLPASS_DELAY_A = 4270;
	localparam int ALLPASS_DELAY_B = 1451;

	localparam logic [16:0] WET_FULL = 17'd65536;

	typedef enum logic [2:0] {
		REG_WET_MIX   = 3'd0,
		REG_COMB_A    = 3'd1,
		REG_COMB_B    = 3'd2,
		REG_COMB_C    = 3'd3,
		REG_COMB_D    = 3'd4,
		REG_ALLPASS_A = 3'd5,
		REG_ALLPASS_B = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [16:0]               wet_mix;
		logic [COMB_NUM-1:0][15:0] comb_gain;
		logic [15:0]               allpass_gain_a;
		logic [15:0]               allpass_gain_b;
	} cfg_t;

	// Q0.16 product back to sample scale, rounded half up
	function automatic logic signed [24:0] qround(input logic signed [40:0] p);
		logic signed [40:0] t;
		t = p + 41'sd32768;
		return t[40:16];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
		if (v > 27'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -27'sd8388608)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
		if (v > 27'sd32767)
			return 16'sh7FFF;
		else if (v < -27'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

[src/srv_cfg.sv]
module srv_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [16:0]       cfg_data,
	output srv_pkg::cfg_t     cfg
);

	srv_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wet_mix        <= 17'd32768;
			cfg_q.comb_gain[0]   <= 16'd48628;
			cfg_q.comb_gain[1]   <= 16'd48038;
			cfg_q.comb_gain[2]   <= 16'd46858;
			cfg_q.comb_gain[3]   <= 16'd45679;
			cfg_q.allpass_gain_a <= 16'd45875;
			cfg_q.allpass_gain_b <= 16'd45875;
		end else if (cfg_valid) begin
			unique case (srv_pkg::reg_idx_t'(cfg_index))
				srv_pkg::REG_WET_MIX:   cfg_q.wet_mix        <= cfg_data;
				srv_pkg::REG_COMB_A:    cfg_q.comb_gain[0]   <= cfg_data[15:0];
				srv_pkg::REG_COMB_B:    cfg_q.comb_gain[1]   <= cfg_data[15:0];
				srv_pkg::REG_COMB_C:    cfg_q.comb_gain[2]   <= cfg_data[15:0];
				srv_pkg::REG_COMB_D:    cfg_q.comb_gain[3]   <= cfg_data[15:0];
				srv_pkg::REG_ALLPASS_A: cfg_q.allpass_gain_a <= cfg_data[15:0];
				srv_pkg::REG_ALLPASS_B: cfg_q.allpass_gain_b <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// wet share above full acts as full
	always_comb begin
		cfg = cfg_q;
		if (cfg_q.wet_mix > srv_pkg::WET_FULL)
			cfg.wet_mix = srv_pkg::WET_FULL;
	end

endmodule

[src/schroeder_reverb.sv]
// channel   direction  word
// s_axis    in         tdata[15:0] sample_in
// m_axis    out        tdata[15:0] sample_out
// cfg       in         cfg_index register, cfg_data value (always ready)
//
// Nine register stages; one word may enter every cycle while the pipeline advances.
// The whole pipeline advances together when the output register is empty or taken.
// Delay lines read as zero until their write position first wraps; no clear pass.
// Reset clears valid bits and line positions and sets config registers to defaults; line contents are not touched.
module schroeder_reverb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int NC = srv_pkg::COMB_NUM;
	localparam int DA = srv_pkg::ALLPASS_DELAY_A;
	localparam int DB = srv_pkg::ALLPASS_DELAY_B;
	localparam int AWA = $clog2(DA);
	localparam int AWB = $clog2(DB);

	srv_pkg::cfg_t cfg;

	srv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cfg_ready = 1'b1;

	logic adv, in_acc;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	assign adv           = !vld_s9 || m_axis_tready;
	assign in_acc        = s_axis_tvalid && adv;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9} <= '0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// dry sample path
	logic signed [15:0] dry_s1, dry_s2, dry_s3, dry_s4, dry_s5, dry_s6, dry_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			dry_s1 <= s_axis_tdata;
			dry_s2 <= dry_s1;
			dry_s3 <= dry_s2;
			dry_s4 <= dry_s3;
			dry_s5 <= dry_s4;
			dry_s6 <= dry_s5;
			dry_s7 <= dry_s6;
		end
	end

	// combs: read s1, product s2, output and write-back into s3
	logic signed [23:0] comb_y [NC];

	for (genvar i = 0; i < NC; i++) begin : g_comb
		localparam int D  = srv_pkg::COMB_DELAY[i];
		localparam int AW = $clog2(D);

		logic signed [23:0] mem [D];
		logic [AW-1:0]      pos_q, a_s1, a_s2;
		logic               wrap_q, z_s1;
		logic signed [23:0] rd_s1;
		logic signed [40:0] prod_s2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q  <= '0;
				wrap_q <= 1'b0;
			end else if (in_acc) begin
				if (pos_q == AW'(D - 1)) begin
					pos_q  <= '0;
					wrap_q <= 1'b1;
				end else begin
					pos_q <= pos_q + AW'(1);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_s1   <= mem[pos_q];
				z_s1    <= !wrap_q;
				a_s1    <= pos_q;
				a_s2    <= a_s1;
				prod_s2 <= $signed({1'b0, cfg.comb_gain[i]}) * (z_s1 ? 24'sd0 : rd_s1);
			end
			if (adv && vld_s2)
				mem[a_s2] <= comb_y[i];
		end

		assign comb_y[i] = srv_pkg::sat24(27'(dry_s2) - 27'(srv_pkg::qround(prod_s2)));
	end

	logic signed [23:0] wet0_s3;

	always_ff @(posedge clk) begin
		if (adv)
			wet0_s3 <= srv_pkg::sat24(27'(comb_y[0]) + 27'(comb_y[1])
				+ 27'(comb_y[2]) + 27'(comb_y[3]));
	end

	// allpass a: lines read on accept, product s4, output s5
	logic signed [23:0] apa_in_mem [DA];
	logic signed [23:0] apa_out_mem [DA];
	logic [AWA-1:0]     pa_q, pa_s1, pa_s2, pa_s3, pa_s4;
	logic               wa_q, za_s1;
	logic signed [23:0] ina_s1, outa_s1, ina_s2, ina_s3, ina_s4;
	logic signed [40:0] poa_s2, pxa_s4;
	logic signed [24:0] qoa_s3, qoa_s4;
	logic signed [23:0] xa_s4, ya, ya_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q <= '0;
			wa_q <= 1'b0;
		end else if (in_acc) begin
			if (pa_q == AWA'(DA - 1)) begin
				pa_q <= '0;
				wa_q <= 1'b1;
			end else begin
				pa_q <= pa_q + AWA'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ina_s1  <= apa_in_mem[pa_q];
			outa_s1 <= apa_out_mem[pa_q];
			za_s1   <= !wa_q;
			pa_s1   <= pa_q;
			pa_s2   <= pa_s1;
			pa_s3   <= pa_s2;
			pa_s4   <= pa_s3;
			ina_s2  <= za_s1 ? 24'sd0 : ina_s1;
			poa_s2  <= $signed({1'b0, cfg.allpass_gain_a}) * (za_s1 ? 24'sd0 : outa_s1);
			ina_s3  <= ina_s2;
			qoa_s3  <= srv_pkg::qround(poa_s2);
			ina_s4  <= ina_s3;
			qoa_s4  <= qoa_s3;
			xa_s4   <= wet0_s3;
			pxa_s4  <= $signed({1'b0, cfg.allpass_gain_a}) * wet0_s3;
			ya_s5   <= ya;
		end
		if (adv && vld_s4) begin
			apa_in_mem[pa_s4]  <= xa_s4;
			apa_out_mem[pa_s4] <= ya;
		end
	end

	assign ya = srv_pkg::sat24(27'(qoa_s4) + 27'(ina_s4) - 27'(srv_pkg::qround(pxa_s4)));

	// allpass b: lines read on accept, product s6, output s7
	logic signed [23:0] apb_in_mem [DB];
	logic signed [23:0] apb_out_mem [DB];
	logic [AWB-1:0]     pb_q, pb_s1, pb_s2, pb_s3, pb_s4, pb_s5, pb_s6;
	logic               wb_q, zb_s1;
	logic signed [23:0] inb_s1, outb_s1, inb_s2, inb_s3, inb_s4, inb_s5, inb_s6;
	logic signed [40:0] pob_s2, pxb_s6;
	logic signed [24:0] qob_s3, qob_s4, qob_s5, qob_s6;
	logic signed [23:0] xb_s6, yb, yb_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pb_q <= '0;
			wb_q <= 1'b0;
		end else if (in_acc) begin
			if (pb_q == AWB'(DB - 1)) begin
				pb_q <= '0;
				wb_q <= 1'b1;
			end else begin
				pb_q <= pb_q + AWB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inb_s1  <= apb_in_mem[pb_q];
			outb_s1 <= apb_out_mem[pb_q];
			zb_s1   <= !wb_q;
			pb_s1   <= pb_q;
			pb_s2   <= pb_s1;
			pb_s3   <= pb_s2;
			pb_s4   <= pb_s3;
			pb_s5   <= pb_s4;
			pb_s6   <= pb_s5;
			inb_s2  <= zb_s1 ? 24'sd0 : inb_s1;
			pob_s2  <= $signed({1'b0, cfg.allpass_gain_b}) * (zb_s1 ? 24'sd0 : outb_s1);
			inb_s3  <= inb_s2;
			inb_s4  <= inb_s3;
			inb_s5  <= inb_s4;
			inb_s6  <= inb_s5;
			qob_s3  <= srv_pkg::qround(pob_s2);
			qob_s4  <= qob_s3;
			qob_s5  <= qob_s4;
			qob_s6  <= qob_s5;
			xb_s6   <= ya_s5;
			pxb_s6  <= $signed({1'b0, cfg.allpass_gain_b}) * ya_s5;
			yb_s7   <= yb;
		end
		if (adv && vld_s6) begin
			apb_in_mem[pb_s6]  <= xb_s6;
			apb_out_mem[pb_s6] <= yb;
		end
	end

	assign yb = srv_pkg::sat24(27'(qob_s6) + 27'(inb_s6) - 27'(srv_pkg::qround(pxb_s6)));

	// wet/dry mix
	logic signed [41:0] mw_s8;
	logic signed [33:0] md_s8;
	logic signed [42:0] mix;
	logic signed [15:0] out_s9;

	assign mix = 43'(mw_s8) + 43'(md_s8) + 43'sd32768;

	always_ff @(posedge clk) begin
		if (adv) begin
			mw_s8  <= $signed({1'b0, cfg.wet_mix}) * yb_s7;
			md_s8  <= $signed({1'b0, srv_pkg::WET_FULL - cfg.wet_mix}) * dry_s7;
			out_s9 <= srv_pkg::sat16(mix[42:16]);
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata  = out_s9;

endmodule

[src/srv_checker.sv]
module srv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output side");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input word changed while waiting");

endmodule

bind schroeder_reverb srv_checker u_srv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
